// ===== design/lrc_pkg.sv =====
// Shared types and constants for the LRU result cache.
// No dependencies; every other design file imports this package.
package lrc_pkg;

  // Number of cache entries and the index width that follows from it.
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Fixed field widths of the request and response.
  localparam int KEY_W   = 32;
  localparam int RES_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int STAMP_W = 64;

  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  // Operation codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_ADD   = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_last;
  } ctl_status_t;

endpackage

// ===== design/lrc_req_if.sv =====
// Request channel of the LRU result cache: valid/ready plus the operation fields.
// Depends on lrc_pkg for the field widths.
interface lrc_req_if;
  import lrc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [KEY_W-1:0]        filter_key;
  logic [KEY_W-1:0]        handle_key;
  logic signed [RES_W-1:0] result_in;

  modport source (output valid, kind, filter_key, handle_key, result_in, input ready);
  modport sink   (input valid, kind, filter_key, handle_key, result_in, output ready);

endinterface

// ===== design/lrc_rsp_if.sv =====
// Response channel of the LRU result cache: valid/ready plus the result fields.
// Depends on lrc_pkg for the field widths.
interface lrc_rsp_if;
  import lrc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [RES_W-1:0] cached_result;
  logic [SLOT_W-1:0]       slot_used;
  logic                    evicted;

  modport source (output valid, hit, cached_result, slot_used, evicted, input ready);
  modport sink   (input valid, hit, cached_result, slot_used, evicted, output ready);

endinterface

// ===== design/lrc_ctrl.sv =====
// Controller of the LRU result cache: sequences accept, entry scan and commit.
// Depends on lrc_pkg for the state type and the command/status structs.
module lrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lrc_pkg::ctl_cmd_t   cmd,
  input  lrc_pkg::ctl_status_t status
);
  import lrc_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A committed result is shown until the sink takes it.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTHESIS
  a_load_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_scan_end_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && status.scan_last) |=> (state == ST_FINISH))
    else $error("scan did not end after the last entry");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && state == ST_IDLE))
    else $error("commit did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && out_valid) |-> out_ready)
    else $error("commit would overwrite a pending result");
`endif

endmodule

// ===== design/lrc_datapath.sv =====
// Datapath of the LRU result cache: entry storage, scan index, search
// registers, use counter and the result register. Depends on lrc_pkg.
module lrc_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  lrc_pkg::ctl_cmd_t       cmd,
  output lrc_pkg::ctl_status_t    status,
  input  logic [1:0]              kind,
  input  logic [lrc_pkg::KEY_W-1:0] filter_key,
  input  logic [lrc_pkg::KEY_W-1:0] handle_key,
  input  logic signed [lrc_pkg::RES_W-1:0] result_in,
  output logic                    hit,
  output logic signed [lrc_pkg::RES_W-1:0] cached_result,
  output logic [lrc_pkg::SLOT_W-1:0] slot_used,
  output logic                    evicted
);
  import lrc_pkg::*;

  // Entry storage.
  logic [DEPTH-1:0]   entry_valid;
  logic [KEY_W-1:0]   entry_filter [DEPTH];
  logic [KEY_W-1:0]   entry_handle [DEPTH];
  logic [RES_W-1:0]   entry_result [DEPTH];
  logic [STAMP_W-1:0] entry_stamp  [DEPTH];
  logic [STAMP_W-1:0] use_counter;

  // Latched request.
  logic [1:0]       kind_q;
  logic [KEY_W-1:0] fkey_q;
  logic [KEY_W-1:0] hkey_q;
  logic [RES_W-1:0] rval_q;

  // Scan index and search results.
  logic [IDX_W-1:0]   idx;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [RES_W-1:0]   found_res;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   min_idx;
  logic [STAMP_W-1:0] min_stamp;

  logic             key_match;
  logic [IDX_W-1:0] pick_idx;
  logic             is_clear, is_check, is_add;

  assign status.scan_last = (idx == LAST_IDX);

  assign key_match = entry_valid[idx] && (entry_filter[idx] == fkey_q) &&
                     (entry_handle[idx] == hkey_q);
  assign pick_idx  = free_found ? free_idx : min_idx;
  assign is_clear  = (kind_q == KIND_CLEAR);
  assign is_check  = (kind_q == KIND_CHECK);
  assign is_add    = (kind_q == KIND_ADD);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      fkey_q <= filter_key;
      hkey_q <= handle_key;
      rval_q <= result_in;
    end
  end

  // Scan index and search flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (!status.scan_last) begin
        idx <= idx + 1'b1;
      end
      if (!found && key_match) begin
        found <= 1'b1;
      end
      if (!free_found && !entry_valid[idx]) begin
        free_found <= 1'b1;
      end
    end
  end

  // Search payload: first match, first free slot and the oldest stamp.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (!found && key_match) begin
        found_idx <= idx;
        found_res <= entry_result[idx];
      end
      if (!free_found && !entry_valid[idx]) begin
        free_idx <= idx;
      end
      // Strict compare keeps the lowest index among equal stamps.
      if (idx == '0 || entry_stamp[idx] < min_stamp) begin
        min_idx   <= idx;
        min_stamp <= entry_stamp[idx];
      end
    end
  end

  // Valid bits and use counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      use_counter <= STAMP_W'(1);
    end else if (cmd.commit) begin
      if (is_clear) begin
        entry_valid <= '0;
      end else if (is_add) begin
        entry_valid[pick_idx] <= 1'b1;
      end
      if ((is_clear || is_check || is_add) && use_counter != STAMP_MAX) begin
        use_counter <= use_counter + 1'b1;
      end
    end
  end

  // Entry contents; a cleared entry is never read before it is written again.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_add) begin
        entry_filter[pick_idx] <= fkey_q;
        entry_handle[pick_idx] <= hkey_q;
        entry_result[pick_idx] <= rval_q;
        entry_stamp[pick_idx]  <= use_counter;
      end else if (is_check && found) begin
        entry_stamp[found_idx] <= use_counter;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= 1'b0;
      cached_result <= '0;
      slot_used     <= '0;
      evicted       <= 1'b0;
      if (is_check && found) begin
        hit           <= 1'b1;
        cached_result <= found_res;
        slot_used     <= SLOT_W'(found_idx);
      end else if (is_add) begin
        slot_used <= SLOT_W'(pick_idx);
        evicted   <= !free_found;
      end
    end
  end

`ifndef SYNTHESIS
  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    use_counter != '0)
    else $error("use counter reached zero");

  a_hit_only_on_check: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !(is_check && found)) |=> !hit)
    else $error("hit reported for a request that did not hit");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && is_add) |=> entry_valid[$past(pick_idx)])
    else $error("added entry not marked valid");
`endif

endmodule

// ===== design/lru_result_cache_core.sv =====
// A request is accepted in the idle state; the scan state then reads one entry per cycle,
// and the finish state commits the result into the response register, where it is shown.
// A new request is accepted only after the previous one has been committed.
// A pending response does not stall the next request until that request's commit cycle.
// Reset (rst, synchronous, active high) empties the cache and sets the use counter to one.
// Reset takes effect at once; there is no clearing pass.
// Top level of the LRU result cache: joins controller and datapath to the channels.
module lru_result_cache_core (
  input logic      clk,
  input logic      rst,
  lrc_req_if.sink  req,
  lrc_rsp_if.source rsp
);
  import lrc_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  // Sequencing.
  lrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Storage, search and result.
  lrc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (req.kind),
    .filter_key    (req.filter_key),
    .handle_key    (req.handle_key),
    .result_in     (req.result_in),
    .hit           (rsp.hit),
    .cached_result (rsp.cached_result),
    .slot_used     (rsp.slot_used),
    .evicted       (rsp.evicted)
  );

endmodule

// ===== sim/tb_lru_result_cache_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_result_cache_core: directed and random requests with an
// in-bench cache predictor and in-order response checking.
// Depends on lrc_pkg, lrc_req_if, lrc_rsp_if and the core RTL.
module tb_lru_result_cache_core;
  import lrc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LATENCY     = DEPTH + 2;
  localparam int RANDOM_REQS = 1050;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_N      = 12;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_W-1:0]        fkey;
    logic [KEY_W-1:0]        hkey;
    logic signed [RES_W-1:0] rval;
  } cache_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [RES_W-1:0] result;
    logic [SLOT_W-1:0]       slot;
    logic                    evicted;
  } cache_rsp_t;

  logic clk;
  logic rst;

  lrc_req_if req_ch();
  lrc_rsp_if rsp_ch();

  lru_result_cache_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted cache contents.
  logic                    line_valid  [DEPTH];
  logic [KEY_W-1:0]        line_filter [DEPTH];
  logic [KEY_W-1:0]        line_handle [DEPTH];
  logic signed [RES_W-1:0] line_result [DEPTH];
  logic [STAMP_W-1:0]      line_stamp  [DEPTH];
  logic [STAMP_W-1:0]      op_counter;

  cache_req_t request_backlog[$];
  cache_rsp_t expected_responses[$];
  cache_req_t in_flight;
  cache_rsp_t predicted;
  cache_rsp_t expected_rsp;

  // Key pool: three filters crossed with four handles, so that keys share either part.
  logic [KEY_W-1:0] pool_filter [3];
  logic [KEY_W-1:0] pool_handle [4];

  int sent_cnt;
  int rsp_cnt;
  int dir_count;
  int phase1_start;
  int phase2_start;
  int send_idle_pct;
  int rcv_idle_pct;
  int fault_count;
  int stall_cycles;

  function automatic void queue_request(logic [1:0] kind, logic [KEY_W-1:0] fkey,
                                        logic [KEY_W-1:0] hkey, logic [RES_W-1:0] rval);
    cache_req_t rq;
    rq.kind = kind;
    rq.fkey = fkey;
    rq.hkey = hkey;
    rq.rval = rval;
    request_backlog.push_back(rq);
  endfunction

  function automatic void wipe_lines();
    for (int i = 0; i < DEPTH; i++) begin
      line_valid[i]  = 1'b0;
      line_filter[i] = '0;
      line_handle[i] = '0;
      line_result[i] = '0;
      line_stamp[i]  = '0;
    end
  endfunction

  // Applies one request to the predicted cache and returns the response it should give.
  function automatic cache_rsp_t predict_cache_response(cache_req_t rq);
    cache_rsp_t rs;
    int pick;
    logic advance;
    rs = '0;
    pick = -1;
    advance = 1'b1;
    case (rq.kind)
      KIND_CLEAR: wipe_lines();
      KIND_CHECK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (pick < 0 && line_valid[i] && line_filter[i] == rq.fkey &&
              line_handle[i] == rq.hkey) begin
            pick = i;
          end
        end
        if (pick >= 0) begin
          rs.hit = 1'b1;
          rs.result = line_result[pick];
          rs.slot = SLOT_W'(pick);
          line_stamp[pick] = op_counter;
        end
      end
      KIND_ADD: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (pick < 0 && !line_valid[i]) begin
            pick = i;
          end
        end
        // No free line: replace the oldest stamp, lowest index on a tie.
        if (pick < 0) begin
          pick = 0;
          for (int i = 1; i < DEPTH; i++) begin
            if (line_stamp[i] < line_stamp[pick]) begin
              pick = i;
            end
          end
          rs.evicted = 1'b1;
        end
        line_valid[pick]  = 1'b1;
        line_filter[pick] = rq.fkey;
        line_handle[pick] = rq.hkey;
        line_result[pick] = rq.rval;
        line_stamp[pick]  = op_counter;
        rs.slot = SLOT_W'(pick);
      end
      default: advance = 1'b0;
    endcase
    // The operation counter saturates instead of wrapping.
    if (advance && op_counter != STAMP_MAX) begin
      op_counter = op_counter + 1'b1;
    end
    return rs;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: predicts each accepted request and presents the next one from the backlog.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      wipe_lines();
      op_counter = 1;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted = predict_cache_response(in_flight);
        expected_responses.push_back(predicted);
        sent_cnt++;
      end
      rcv_idle_pct <= (sent_cnt < phase1_start) ? 63 : (sent_cnt < phase2_start) ? 10 : 0;
      send_idle_pct = (sent_cnt < phase1_start) ? 10 : (sent_cnt < phase2_start) ? 63 : 0;
      if (!req_ch.valid || req_ch.ready) begin
        // At each phase boundary the sender holds off until every response is back.
        if (request_backlog.size() != 0 &&
            !((sent_cnt == dir_count || sent_cnt == phase1_start ||
               sent_cnt == phase2_start) && rsp_cnt != sent_cnt) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_flight = request_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.kind       <= in_flight.kind;
          req_ch.filter_key <= in_flight.fkey;
          req_ch.handle_key <= in_flight.hkey;
          req_ch.result_in  <= in_flight.rval;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each accepted response with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_cnt <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_cnt <= rsp_cnt + 1;
        if (expected_responses.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("%0t: response with no request outstanding:", $time);
            $display("  hit=%b result=%h slot=%0d evicted=%b",
                     rsp_ch.hit, rsp_ch.cached_result, rsp_ch.slot_used, rsp_ch.evicted);
          end
        end else begin
          expected_rsp = expected_responses.pop_front();
          if (rsp_ch.hit !== expected_rsp.hit ||
              rsp_ch.cached_result !== expected_rsp.result ||
              rsp_ch.slot_used !== expected_rsp.slot ||
              rsp_ch.evicted !== expected_rsp.evicted) begin
            fault_count++;
            if (fault_count <= REPORT_MAX) begin
              $display("%0t: response %0d mismatch: expected hit=%b result=%h slot=%0d evicted=%b",
                       $time, rsp_cnt, expected_rsp.hit, expected_rsp.result, expected_rsp.slot,
                       expected_rsp.evicted);
              $display("%0t: response %0d mismatch: actual   hit=%b result=%h slot=%0d evicted=%b",
                       $time, rsp_cnt, rsp_ch.hit, rsp_ch.cached_result, rsp_ch.slot_used,
                       rsp_ch.evicted);
            end
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Cycles in which neither channel moves a request or a response.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    int idx;
    logic [1:0] kind;
    logic [KEY_W-1:0] fkey;
    logic [KEY_W-1:0] hkey;

    rst = 1'b1;

    // Directed part: empty cache, key extremes, partial key matches, duplicates, eviction,
    // clear and the unused operation code.
    queue_request(KIND_CHECK, '0, '0, 32'h1234_5678);
    queue_request(KIND_ADD, '0, '0, 32'h8000_0000);
    queue_request(KIND_ADD, '1, '1, 32'h7FFF_FFFF);
    queue_request(KIND_CHECK, '0, '0, '0);
    queue_request(KIND_CHECK, '1, '1, '1);
    queue_request(KIND_CHECK, '0, '1, '0);
    queue_request(KIND_CHECK, '1, '0, '0);
    queue_request(KIND_UNUSED, '1, '1, '1);
    queue_request(KIND_ADD, '0, '0, 32'hFFFF_FFFF);
    queue_request(KIND_CHECK, '0, '0, '0);
    for (int i = 3; i < 8; i++) begin
      queue_request(KIND_ADD, KEY_W'(32'h100 + i), KEY_W'(32'h200 + i), RES_W'(i));
    end
    queue_request(KIND_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001);
    queue_request(KIND_ADD, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hFFFF_FFFE);
    queue_request(KIND_CHECK, 32'h103, 32'h203, '0);
    queue_request(KIND_CLEAR, '1, '1, '1);
    queue_request(KIND_CHECK, '1, '1, '0);
    queue_request(KIND_ADD, '1, '1, 32'h0000_0001);
    queue_request(KIND_CLEAR, '0, '0, '0);
    dir_count = request_backlog.size();
    phase1_start = dir_count + RANDOM_REQS / 3;
    phase2_start = dir_count + 2 * RANDOM_REQS / 3;

    foreach (pool_filter[i]) pool_filter[i] = $urandom;
    foreach (pool_handle[i]) pool_handle[i] = $urandom;

    // Random part: mostly checks and adds over a small key pool so that the cache fills,
    // hits and evicts; rare clears, unused codes, random keys and one-bit near misses.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(99);
      kind = (r < 2) ? KIND_CLEAR : (r < 5) ? KIND_UNUSED : (r < 55) ? KIND_CHECK : KIND_ADD;
      idx = $urandom_range(POOL_N - 1);
      fkey = pool_filter[idx % 3];
      hkey = pool_handle[idx / 3];
      r = $urandom_range(99);
      if (r < 8) begin
        fkey = $urandom;
        hkey = $urandom;
      end else if (r < 14) begin
        if (r[0]) fkey[$urandom_range(KEY_W - 1)] ^= 1'b1;
        else hkey[$urandom_range(KEY_W - 1)] ^= 1'b1;
      end
      queue_request(kind, fkey, hkey, $urandom);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || req_ch.valid || expected_responses.size() != 0) begin
      @(negedge clk);
    end
    repeat (LATENCY + 2) @(negedge clk);

    if (fault_count == 0 && expected_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
